/* rtl/core/tia_pkg.sv */
`timescale 1ns / 1ps

package tia_pkg;

  // bitmap word handled by the search unit
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  typedef logic [WORD_W-1:0] tia_word_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC_FIRST = 2'd0,
    FUNC_ALLOC_SPEC  = 2'd1,
    FUNC_FREE        = 2'd2,
    FUNC_MARK_USED   = 2'd3
  } tia_func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } tia_state_e;

  // result of the find-first-free unit
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } tia_ffs_t;

endpackage

/* rtl/core/tia_ffs.sv */
`timescale 1ns / 1ps

module tia_ffs (
  input  tia_pkg::tia_word_t word_i,
  input  tia_pkg::tia_word_t mask_i,
  output tia_pkg::tia_ffs_t  res_o
);

  tia_pkg::tia_word_t cand;

  assign cand = word_i & mask_i;

  // lowest set bit wins
  always_comb begin
    res_o = '0;
    for (int b = tia_pkg::WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.hit = 1'b1;
        res_o.pos = tia_pkg::BIT_W'(b);
      end
    end
  end

endmodule

/* rtl/core/tia_bitmap_mem.sv */
`timescale 1ns / 1ps

module tia_bitmap_mem #(
  parameter int NUM_WORDS = 32,
  parameter int AW        = 5
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output tia_pkg::tia_word_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  tia_pkg::tia_word_t wr_data_i
);

  tia_pkg::tia_word_t mem_q [NUM_WORDS];
  tia_pkg::tia_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/table_id_allocator.sv */
`timescale 1ns / 1ps
// identifier allocator over a free bitmap with a next-fit search hint
// input channel: in_valid_i / in_stall_o carries func_i and req_id_i; one item
//   gives exactly one result on out_valid_o / out_stall_i (ok_o, granted_id_o)
// the bitmap lives in a single-port-read, single-port-write word memory of
//   32-bit words; one find-first-set unit examines one word per cycle
// free, mark used and allocate specific pass through lookup, modify and done
//   to the output register (an id out of range goes straight to done);
//   allocate first scans upward from the hint word, then wraps from word
//   zero, and starts with the wrap pass once the hint has reached NUM_IDS
// one item at a time: in_stall_o is high from accept until the result has
//   been moved into the output register
// reset: a fill sweep writes the initial map, one word per cycle, over all
//   ceil(NUM_IDS / 32) words; id zero starts reserved, the rest free, and
//   in_stall_o stays high until the sweep ends
// a stalled output holds its item; the next item may be accepted while it
//   waits, but its result stays inside until the output register frees up
module table_id_allocator #(
  parameter int NUM_IDS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [9:0] req_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ok_o,
  output logic [9:0] granted_id_o
);

  localparam int NUM_WORDS = (NUM_IDS + tia_pkg::WORD_W - 1) / tia_pkg::WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = $clog2(NUM_WORDS + 1);
  localparam int HINT_W    = $clog2(NUM_IDS + 1);
  localparam logic [AW-1:0] LAST_W = AW'(NUM_WORDS - 1);

  // initial map word: every existing id free except id zero
  function automatic tia_pkg::tia_word_t init_word(input logic [AW-1:0] w);
    int                 base;
    tia_pkg::tia_word_t v;
    base = int'(w) * tia_pkg::WORD_W;
    for (int b = 0; b < tia_pkg::WORD_W; b++) begin
      v[b] = ((base + b) < NUM_IDS) && ((base + b) != 0);
    end
    return v;
  endfunction

  tia_pkg::tia_state_e state_q, state_d;
  tia_pkg::tia_func_e  func_q, func_d;
  logic [9:0]          req_q, req_d;
  logic [HINT_W-1:0]   hint_q, hint_d;
  logic                pass_q, pass_d;     // 0 upward from hint, 1 wrap from zero
  logic [CW-1:0]       rd_addr_q, rd_addr_d;
  logic                chk_vld_q, chk_vld_d;
  logic [AW-1:0]       chk_addr_q, chk_addr_d;
  logic [AW-1:0]       init_q, init_d;
  logic                res_ok_q, res_ok_d;
  logic [9:0]          res_id_q, res_id_d;
  logic                out_vld_q, out_vld_d;
  logic                out_ok_q, out_ok_d;
  logic [9:0]          out_id_q, out_id_d;

  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  tia_pkg::tia_word_t  mem_rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  tia_pkg::tia_word_t  mem_wdata;

  tia_pkg::tia_word_t  scan_mask;
  tia_pkg::tia_ffs_t   ffs;

  logic [HINT_W-1:0]   hint_word;
  logic [4:0]          hint_bit;
  logic [AW-1:0]       req_word;
  tia_pkg::tia_word_t  req_onehot;
  logic                in_range;
  logic                rd_issue;

  assign hint_word  = hint_q >> 5;
  assign hint_bit   = 5'(hint_q & HINT_W'(31));
  assign req_word   = AW'(req_q >> 5);
  assign req_onehot = tia_pkg::tia_word_t'(1) << req_q[4:0];
  assign in_range   = (32'(req_id_i) < NUM_IDS);
  assign rd_issue   = (rd_addr_q < CW'(NUM_WORDS));

  // upward pass ignores ids below the hint; the wrap pass sees every id,
  // since nothing at or above the hint was free
  always_comb begin
    if (pass_q || (HINT_W'(chk_addr_q) > hint_word)) begin
      scan_mask = '1;
    end else if (HINT_W'(chk_addr_q) == hint_word) begin
      scan_mask = {tia_pkg::WORD_W{1'b1}} << hint_bit;
    end else begin
      scan_mask = '0;
    end
  end

  tia_bitmap_mem #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  tia_ffs u_ffs (
    .word_i (mem_rdata),
    .mask_i (scan_mask),
    .res_o  (ffs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tia_pkg::ST_INIT;
      hint_q    <= HINT_W'(1);
      pass_q    <= 1'b0;
      rd_addr_q <= '0;
      chk_vld_q <= 1'b0;
      init_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hint_q    <= hint_d;
      pass_q    <= pass_d;
      rd_addr_q <= rd_addr_d;
      chk_vld_q <= chk_vld_d;
      init_q    <= init_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    req_q      <= req_d;
    chk_addr_q <= chk_addr_d;
    res_ok_q   <= res_ok_d;
    res_id_q   <= res_id_d;
    out_ok_q   <= out_ok_d;
    out_id_q   <= out_id_d;
  end

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    req_d      = req_q;
    hint_d     = hint_q;
    pass_d     = pass_q;
    rd_addr_d  = rd_addr_q;
    chk_vld_d  = chk_vld_q;
    chk_addr_d = chk_addr_q;
    init_d     = init_q;
    res_ok_d   = res_ok_q;
    res_id_d   = res_id_q;
    out_vld_d  = out_vld_q;
    out_ok_d   = out_ok_q;
    out_id_d   = out_id_q;
    mem_re     = 1'b0;
    mem_raddr  = req_word;
    mem_we     = 1'b0;
    mem_waddr  = chk_addr_q;
    mem_wdata  = mem_rdata;

    // output register drains when taken
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      tia_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = init_word(init_q);
        if (init_q == LAST_W) begin
          state_d = tia_pkg::ST_IDLE;
        end else begin
          init_d = init_q + AW'(1);
        end
      end

      tia_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d = tia_pkg::tia_func_e'(func_i);
          req_d  = req_id_i;
          if (tia_pkg::tia_func_e'(func_i) == tia_pkg::FUNC_ALLOC_FIRST) begin
            chk_vld_d = 1'b0;
            if (hint_q >= HINT_W'(NUM_IDS)) begin
              pass_d    = 1'b1;
              rd_addr_d = '0;
            end else begin
              pass_d    = 1'b0;
              rd_addr_d = CW'(hint_q >> 5);
            end
            state_d = tia_pkg::ST_SCAN;
          end else if (in_range) begin
            state_d = tia_pkg::ST_LOOKUP;
          end else begin
            res_ok_d = 1'b0;
            res_id_d = '0;
            state_d  = tia_pkg::ST_DONE;
          end
        end
      end

      tia_pkg::ST_LOOKUP: begin
        mem_re    = 1'b1;
        mem_raddr = req_word;
        state_d   = tia_pkg::ST_MODIFY;
      end

      tia_pkg::ST_MODIFY: begin
        mem_waddr = req_word;
        res_ok_d  = 1'b0;
        res_id_d  = '0;
        unique case (func_q)
          tia_pkg::FUNC_ALLOC_SPEC: begin
            if (mem_rdata[req_q[4:0]]) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata & ~req_onehot;
              res_ok_d  = 1'b1;
              res_id_d  = req_q;
            end
          end
          tia_pkg::FUNC_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | req_onehot;
            res_ok_d  = 1'b1;
          end
          tia_pkg::FUNC_MARK_USED: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~req_onehot;
            res_ok_d  = 1'b1;
          end
          default: begin
            res_ok_d = 1'b0;
          end
        endcase
        state_d = tia_pkg::ST_DONE;
      end

      tia_pkg::ST_SCAN: begin
        // read one word ahead while the previous one is checked
        mem_re     = rd_issue;
        mem_raddr  = rd_addr_q[AW-1:0];
        chk_vld_d  = rd_issue;
        chk_addr_d = rd_addr_q[AW-1:0];
        if (rd_issue) begin
          rd_addr_d = rd_addr_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (ffs.hit) begin
            mem_we    = 1'b1;
            mem_waddr = chk_addr_q;
            mem_wdata = mem_rdata & ~(tia_pkg::tia_word_t'(1) << ffs.pos);
            res_ok_d  = 1'b1;
            res_id_d  = 10'({chk_addr_q, ffs.pos});
            if (!pass_q) begin
              hint_d = hint_q + HINT_W'(1);
            end
            state_d = tia_pkg::ST_DONE;
          end else if (chk_addr_q == LAST_W) begin
            if (!pass_q) begin
              // wrap: restart at word zero, drop the read in flight
              pass_d    = 1'b1;
              rd_addr_d = '0;
              chk_vld_d = 1'b0;
            end else begin
              res_ok_d = 1'b0;
              res_id_d = '0;
              state_d  = tia_pkg::ST_DONE;
            end
          end
        end
      end

      tia_pkg::ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_ok_d  = res_ok_q;
          out_id_d  = res_id_q;
          state_d   = tia_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tia_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o   = (state_q != tia_pkg::ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign ok_o         = out_ok_q;
  assign granted_id_o = out_id_q;

  // the hint never runs past the pool size
  a_hint_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= HINT_W'(NUM_IDS))
    else $error("scan hint beyond pool size");

  // a failed item never carries an id
  a_fail_no_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_id_o == '0)
    else $error("failed result with nonzero id");

  // a hit in the upward pass moves the hint by exactly one
  a_hint_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tia_pkg::ST_SCAN) && chk_vld_q && ffs.hit && !pass_q
      |=> hint_q == $past(hint_q) + HINT_W'(1))
    else $error("hint did not advance by one");

  // the map is only written by the fill sweep, an update or a scan hit
  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == tia_pkg::ST_INIT) || (state_q == tia_pkg::ST_MODIFY)
      || (state_q == tia_pkg::ST_SCAN))
    else $error("bitmap write outside update states");

endmodule

/* verif/table_id_allocator_test.sv */
`timescale 1ns / 1ps

class id_pool_scoreboard;
  localparam int POOL_SIZE = 1024;

  typedef struct {
    logic       ok;
    logic [9:0] grant;
  } grant_t;

  bit [POOL_SIZE-1:0] free_map;
  int unsigned        hint;
  int unsigned        peak_hint;
  grant_t             grants_q[$];
  int unsigned        errors;
  int unsigned        refused;
  int unsigned        func_count[4];

  function new();
    free_map  = '1;
    free_map[0] = 1'b0;
    hint      = 1;
    peak_hint = 1;
    errors    = 0;
    refused   = 0;
    foreach (func_count[i]) func_count[i] = 0;
  endfunction

  task report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function int unsigned pending();
    return grants_q.size();
  endfunction

  // work out what the block answers to one accepted request
  function void note_request(input tia_pkg::tia_func_e f, input logic [9:0] id);
    grant_t exp_g;
    int     found;
    int     i;
    exp_g.ok    = 1'b0;
    exp_g.grant = '0;
    found = -1;
    func_count[f]++;
    case (f)
      tia_pkg::FUNC_ALLOC_FIRST: begin
        // upward pass from the hint; a hit bumps the hint by one only
        for (i = hint; i < POOL_SIZE; i++) begin
          if (free_map[i]) begin
            found = i;
            break;
          end
        end
        if (found >= 0) begin
          hint++;
        end else begin
          // wrap pass below the hint
          for (i = 0; i < hint && i < POOL_SIZE; i++) begin
            if (free_map[i]) begin
              found = i;
              break;
            end
          end
        end
        if (found >= 0) begin
          free_map[found] = 1'b0;
          exp_g.ok    = 1'b1;
          exp_g.grant = found[9:0];
        end
      end
      tia_pkg::FUNC_ALLOC_SPEC: begin
        if (id < POOL_SIZE && free_map[id]) begin
          free_map[id] = 1'b0;
          exp_g.ok    = 1'b1;
          exp_g.grant = id;
        end
      end
      tia_pkg::FUNC_FREE: begin
        if (id < POOL_SIZE) begin
          free_map[id] = 1'b1;
          exp_g.ok     = 1'b1;
        end
      end
      default: begin
        if (id < POOL_SIZE) begin
          free_map[id] = 1'b0;
          exp_g.ok     = 1'b1;
        end
      end
    endcase
    if (hint > peak_hint) peak_hint = hint;
    if (!exp_g.ok) refused++;
    grants_q.push_back(exp_g);
  endfunction

  task check_result(input logic ok, input logic [9:0] grant);
    grant_t exp_g;
    if (grants_q.size() == 0) begin
      report($sformatf("result ok=%0b id=%0d with no request outstanding", ok, grant));
    end else begin
      exp_g = grants_q.pop_front();
      if (ok !== exp_g.ok)
        report($sformatf("ok is %b, predicted %b", ok, exp_g.ok));
      if (grant !== exp_g.grant)
        report($sformatf("granted id is %0d, predicted %0d", grant, exp_g.grant));
    end
  endtask

  task check_drained();
    if (grants_q.size() != 0)
      report($sformatf("%0d results never arrived", grants_q.size()));
  endtask
endclass

module table_id_allocator_test;
  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tia_pkg::tia_func_e func      = tia_pkg::FUNC_ALLOC_FIRST;
  logic [9:0]         req_id    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [9:0]         granted_id;

  // idle_on enables random gaps on both sides; hold_req asks the receiver
  // for one long hold-off while the sender keeps pushing
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycles   = 0;

  id_pool_scoreboard pool = new();

  table_id_allocator DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .req_id_i     (req_id),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .ok_o         (ok),
    .granted_id_o (granted_id)
  );

  always #(CLK_HALF) clk = ~clk;

  // watchdog, sized well above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // both handshakes are sampled here, with pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pool.note_request(func, req_id);
    if (rst_n && out_valid && !out_stall) pool.check_result(ok, granted_id);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item, maybe after a random gap, and hold it until accepted
  task automatic send_request(input tia_pkg::tia_func_e f, input logic [9:0] id);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    req_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // weights in percent; mark used takes what is left
  function automatic tia_pkg::tia_func_e pick_func(input int w_first, input int w_spec,
                                                   input int w_free);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_first) pick_func = tia_pkg::FUNC_ALLOC_FIRST;
    else if (r < w_first + w_spec) pick_func = tia_pkg::FUNC_ALLOC_SPEC;
    else if (r < w_first + w_spec + w_free) pick_func = tia_pkg::FUNC_FREE;
    else pick_func = tia_pkg::FUNC_MARK_USED;
  endfunction

  // ids lean toward the ends of the range now and then
  function automatic logic [9:0] pick_id();
    case ($urandom_range(0, 9))
      0:       pick_id = 10'd0;
      1:       pick_id = 10'h3FF;
      2:       pick_id = 10'($urandom_range(1, 4));
      3:       pick_id = 10'($urandom_range(1019, 1022));
      default: pick_id = 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin : stimulus
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reserved id zero, ends of the range, taken ids, refrees
    send_request(tia_pkg::FUNC_ALLOC_FIRST, 10'h3FF);   // req_id ignored, gets id 1
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'd0);     // zero reserved after reset
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'h3FF);
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'h3FF);   // already taken
    send_request(tia_pkg::FUNC_FREE,        10'd0);     // zero becomes usable
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'd0);
    send_request(tia_pkg::FUNC_FREE,        10'd0);
    send_request(tia_pkg::FUNC_ALLOC_FIRST, 10'd0);
    send_request(tia_pkg::FUNC_FREE,        10'd512);   // freeing a free id
    send_request(tia_pkg::FUNC_MARK_USED,   10'h3FF);   // marking a used id
    send_request(tia_pkg::FUNC_MARK_USED,   10'd3);
    send_request(tia_pkg::FUNC_ALLOC_FIRST, 10'h155);   // skips the marked id
    send_request(tia_pkg::FUNC_FREE,        10'd1);
    send_request(tia_pkg::FUNC_ALLOC_FIRST, 10'h2AA);   // upward pass wins over id 1
    send_request(tia_pkg::FUNC_MARK_USED,   10'd1022);
    send_request(tia_pkg::FUNC_FREE,        10'h3FF);
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'h3FF);
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'd1022);  // taken by mark used
    send_request(tia_pkg::FUNC_FREE,        10'd1022);
    send_request(tia_pkg::FUNC_ALLOC_SPEC,  10'd1022);

    // mostly allocate first: drains the pool, drives the hint to the top and
    // runs into exhaustion; a stretch in the middle goes without idling
    for (k = 0; k < 1150; k++) begin
      if (k == 600) idle_on = 1'b0;
      if (k == 800) idle_on = 1'b1;
      send_request(pick_func(95, 2, 2), pick_id());
    end

    // churn on a nearly full pool; starts under a long receiver hold-off,
    // and the tail runs with no idling at all
    hold_req = 1'b1;
    for (k = 0; k < 650; k++) begin
      if (k == 350) idle_on = 1'b0;
      send_request(pick_func(35, 15, 35), pick_id());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pool.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    pool.check_drained();

    $display("requests: %0d allocate first, %0d allocate specific, %0d free, %0d mark used",
             pool.func_count[tia_pkg::FUNC_ALLOC_FIRST],
             pool.func_count[tia_pkg::FUNC_ALLOC_SPEC],
             pool.func_count[tia_pkg::FUNC_FREE],
             pool.func_count[tia_pkg::FUNC_MARK_USED]);
    $display("%0d refused, search hint peaked at %0d, %0d mismatches",
             pool.refused, pool.peak_hint, pool.errors);
    if (pool.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
